/* rtl/core/ps2mpd_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared types and constants for the packet decoder modules.
// ----------------------------------------------------------------------------
package ps2mpd_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned WheelW = 16;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgDW  = 12;

  localparam logic [ByteW-1:0] SYNC_MASK     = 8'h08;
  localparam logic [ByteW-1:0] OVERFLOW_MASK = 8'hC0;
  localparam logic [ByteW-1:0] BUTTON_MASK   = 8'h07;

  localparam logic [PosW-1:0] X_LIMIT_RST = 12'd79;
  localparam logic [PosW-1:0] Y_LIMIT_RST = 12'd24;
  localparam logic [PosW-1:0] POS_X_RST   = 12'd40;
  localparam logic [PosW-1:0] POS_Y_RST   = 12'd12;

  typedef enum logic [1:0] {
    CFG_WHEEL_ENABLE = 2'd0,
    CFG_X_LIMIT      = 2'd1,
    CFG_Y_LIMIT      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic            wheel_enable;
    logic [PosW-1:0] x_limit;
    logic [PosW-1:0] y_limit;
  } cfg_t;

  typedef struct packed {
    logic [BtnW-1:0]          buttons;
    logic [PosW-1:0]          pos_x;
    logic [PosW-1:0]          pos_y;
    logic signed [WheelW-1:0] wheel_count;
  } result_t;

endpackage

/* rtl/core/ps2mpd_cfg.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse decoder configuration registers
// Holds wheel mode and the two position limits, written through a simple
// valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module ps2mpd_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [ps2mpd_pkg::CfgDW-1:0] cfg_data,
  output ps2mpd_pkg::cfg_t            cfg
);
  import ps2mpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WHEEL_ENABLE: cfg_nxt.wheel_enable = cfg_data[0];
        CFG_X_LIMIT:      cfg_nxt.x_limit      = cfg_data[PosW-1:0];
        CFG_Y_LIMIT:      cfg_nxt.y_limit      = cfg_data[PosW-1:0];
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_enable <= 1'b0;
      cfg_r.x_limit      <= X_LIMIT_RST;
      cfg_r.y_limit      <= Y_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/ps2mpd_in_reg.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse decoder input register
// Captures one received byte per item and holds it until the decode stage
// has consumed it.
// ----------------------------------------------------------------------------
module ps2mpd_in_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ps2mpd_pkg::ByteW-1:0] in_data_byte,
  input  logic                        s1_fire,
  output logic                        s1_valid,
  output logic [ps2mpd_pkg::ByteW-1:0] s1_byte
);
  import ps2mpd_pkg::*;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;

  assign in_ready = !s1_valid_r || s1_fire;
  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
    end
  end

endmodule

/* rtl/core/ps2mpd_decode.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse packet assembly and decode
// Collects packet bytes, and on the last byte of a packet updates buttons,
// the clamped position and the wheel counter in a single pass.
// ----------------------------------------------------------------------------
module ps2mpd_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ps2mpd_pkg::cfg_t            cfg,
  input  logic                        s1_valid,
  input  logic [ps2mpd_pkg::ByteW-1:0] s1_byte,
  input  logic                        out_free,
  output logic                        s1_fire,
  output logic                        res_load,
  output ps2mpd_pkg::result_t         res
);
  import ps2mpd_pkg::*;

  // Position plus a delta of -128..128 fits in 14 signed bits.
  function automatic logic [PosW-1:0] clamp_pos(input logic [PosW-1:0] pos,
                                                input logic signed [13:0] delta,
                                                input logic [PosW-1:0] limit);
    logic signed [13:0] p;
    p = $signed({2'b00, pos}) + delta;
    if (p[13]) begin
      return '0;
    end else if (p[12:0] > {1'b0, limit}) begin
      return limit;
    end else begin
      return p[PosW-1:0];
    end
  endfunction

  logic [1:0]               idx_r,   idx_nxt;
  logic [ByteW-1:0]         held0_r, held1_r, held2_r;
  logic [PosW-1:0]          pos_x_r, pos_x_nxt;
  logic [PosW-1:0]          pos_y_r, pos_y_nxt;
  logic signed [WheelW-1:0] wheel_r, wheel_nxt;
  logic [BtnW-1:0]          btn_r,   btn_nxt;

  logic [1:0]         last;
  logic               complete;
  logic [ByteW-1:0]   b2;
  logic               ovf;
  logic signed [13:0] dx, dy;
  logic [3:0]         nib;

  assign last     = cfg.wheel_enable ? 2'd3 : 2'd2;
  assign complete = (idx_r != 2'd0) && (idx_r >= last);
  assign s1_fire  = s1_valid && (!complete || out_free);
  assign res_load = s1_fire && complete;

  // With wheel mode dropped mid-packet, byte 2 is already held.
  assign b2  = (idx_r == 2'd2) ? s1_byte : held2_r;
  assign ovf = |(held0_r & OVERFLOW_MASK);
  assign dx  = ovf ? 14'sd0 : $signed({{6{held1_r[7]}}, held1_r});
  assign dy  = ovf ? 14'sd0 : -$signed({{6{b2[7]}}, b2});
  assign nib = s1_byte[3:0];

  always_comb begin
    idx_nxt   = idx_r;
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    wheel_nxt = wheel_r;
    btn_nxt   = btn_r;
    if (s1_fire) begin
      if (idx_r == 2'd0) begin
        if (|(s1_byte & SYNC_MASK)) begin
          idx_nxt = 2'd1;
        end
      end else if (!complete) begin
        idx_nxt = idx_r + 2'd1;
      end else begin
        idx_nxt   = 2'd0;
        btn_nxt   = held0_r[BtnW-1:0] & BUTTON_MASK[BtnW-1:0];
        pos_x_nxt = clamp_pos(pos_x_r, dx, cfg.x_limit);
        pos_y_nxt = clamp_pos(pos_y_r, dy, cfg.y_limit);
        if (cfg.wheel_enable && (nib != 4'd0)) begin
          wheel_nxt = nib[3] ? wheel_r - 16'sd1 : wheel_r + 16'sd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      pos_x_r <= POS_X_RST;
      pos_y_r <= POS_Y_RST;
      wheel_r <= '0;
      btn_r   <= '0;
    end else begin
      idx_r   <= idx_nxt;
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      wheel_r <= wheel_nxt;
      btn_r   <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (idx_r == 2'd0) begin
        held0_r <= s1_byte;
      end else if (!complete && (idx_r == 2'd1)) begin
        held1_r <= s1_byte;
      end else if (!complete && (idx_r == 2'd2)) begin
        held2_r <= s1_byte;
      end
    end
  end

  assign res.buttons     = btn_nxt;
  assign res.pos_x       = pos_x_nxt;
  assign res.pos_y       = pos_y_nxt;
  assign res.wheel_count = wheel_nxt;

endmodule

/* rtl/core/ps2mpd_out_reg.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse decoder result register
// Holds one decoded packet until the consumer takes it.
// ----------------------------------------------------------------------------
module ps2mpd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_load,
  input  ps2mpd_pkg::result_t res,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_ready,
  output ps2mpd_pkg::result_t out_res
);
  import ps2mpd_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

endmodule

/* rtl/core/ps2_mouse_packet_decoder.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Assembles received mouse bytes into three- or four-byte packets and
// reports buttons, clamped position and wheel count once per packet.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_data_byte
//   out_     output     out_valid / out_ready  out_buttons, out_pos_x,
//                                              out_pos_y, out_wheel_count
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken every cycle unless a completed packet is held back.
// A byte waits in the input register; when it completes a packet, its
// result is registered in the result register as the byte leaves the
// input register, and out_valid rises with it. The decode stage updates
// all state in one pass per byte. A result still waiting in the result
// register holds back a packet-completing byte in the input register, and
// with it the input; other bytes keep flowing. Reset is synchronous.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ps2mpd_pkg::ByteW-1:0]          in_data_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ps2mpd_pkg::BtnW-1:0]           out_buttons,
  output logic [ps2mpd_pkg::PosW-1:0]           out_pos_x,
  output logic [ps2mpd_pkg::PosW-1:0]           out_pos_y,
  output logic signed [ps2mpd_pkg::WheelW-1:0]  out_wheel_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [1:0]                            cfg_index,
  input  logic [ps2mpd_pkg::CfgDW-1:0]          cfg_data
);
  import ps2mpd_pkg::*;

  cfg_t             cfg;
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_fire;
  logic             res_load;
  logic             out_free;
  result_t          res;
  result_t          out_res;

  ps2mpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ps2mpd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .s1_fire      (s1_fire),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte)
  );

  ps2mpd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .out_free (out_free),
    .s1_fire  (s1_fire),
    .res_load (res_load),
    .res      (res)
  );

  ps2mpd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_buttons     = out_res.buttons;
  assign out_pos_x       = out_res.pos_x;
  assign out_pos_y       = out_res.pos_y;
  assign out_wheel_count = out_res.wheel_count;

  // A completed packet must never overwrite a result still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid || out_ready))
    else $error("packet result loaded over an untaken result");

  // The reported position is the decoder's position after the packet.
  a_pos_track: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (out_pos_x == u_decode.pos_x_r) && (out_pos_y == u_decode.pos_y_r))
    else $error("reported position differs from decoder state");

  // An accepted byte is always present in the input register next cycle.
  a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted item missing from the input register");

endmodule
